@@ hdl/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// Palette index packer package
// Shared constants, request kinds, the burst record and the byte formatting
// helpers used by the packer datapath.
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int PaletteEntriesDef = 16;
   localparam int PaletteMax        = 16;
   localparam int HeaderBytes       = 4;
   localparam int BurstBytes        = HeaderBytes + PaletteMax;
   localparam int BurstCntW         = $clog2(BurstBytes + 1);
   localparam int CountW            = 5;
   localparam int PendW             = 21;
   localparam int GroupW            = 3;

   localparam logic [BurstCntW-1:0] BurstCountFmt0 = BurstCntW'(HeaderBytes + 16);
   localparam logic [BurstCntW-1:0] BurstCountFmt1 = BurstCntW'(HeaderBytes + 8);

   localparam logic [1:0] REQ_PALETTE = 2'd0;
   localparam logic [1:0] REQ_FRAME   = 2'd1;
   localparam logic [1:0] REQ_PIXEL   = 2'd2;
   localparam logic [1:0] REQ_UNUSED  = 2'd3;

   localparam logic FMT_NIBBLE = 1'b0;
   localparam logic FMT_SPLIT  = 1'b1;

   localparam logic CSR_FORMAT = 1'b0;
   localparam logic CSR_COUNT  = 1'b1;

   typedef struct packed {
      logic [BurstBytes-1:0][7:0] data;
      logic [BurstCntW-1:0]       count;
   } burst_type;

   // BBGGGRRR color byte, red in the low bits
   function automatic logic [7:0] to_332(input logic [23:0] c);
      return {c[7:6], c[15:13], c[23:21]};
   endfunction

   // Eight 3-bit indices into three bytes, the seventh and eighth split
   function automatic logic [23:0] pack_split(input logic [7:0][2:0] c);
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      b0 = {c[6][2], c[0], c[6][1], c[1]};
      b1 = {c[6][0], c[2], c[7][2], c[3]};
      b2 = {c[7][1], c[4], c[7][0], c[5]};
      return {b2, b1, b0};
   endfunction

endpackage

@@ hdl/pip_palette.sv @@
// ----------------------------------------------------------------------------
// Palette store and lookup
// Holds the palette colors, finds the first matching slot for a pixel and
// forms the palette bytes of the frame header.
// ----------------------------------------------------------------------------
module pip_palette import pip_pkg::*; #(
   parameter int PALETTE_ENTRIES = PaletteEntriesDef
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(PALETTE_ENTRIES)-1:0] wr_slot,
   input  logic [23:0]                  color,
   input  logic [CountW-1:0]            eff_count,
   output logic [CountW-1:0]            match_index,
   output logic [PaletteMax-1:0][7:0]   pal_bytes
);

   logic [23:0] pal_ff [PALETTE_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pal_ff[wr_slot] <= color;
      end
   end

   // first match wins: scan from the top down
   always_comb begin
      match_index = eff_count;
      for (int j = PALETTE_ENTRIES - 1; j >= 0; j--) begin
         if (CountW'(j) < eff_count && pal_ff[j] == color) begin
            match_index = CountW'(j);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < PaletteMax; i++) begin
         pal_bytes[i] = 8'hFF;
      end
      for (int j = 0; j < PALETTE_ENTRIES; j++) begin
         if (CountW'(j) < eff_count) begin
            pal_bytes[j] = to_332(pal_ff[j]);
         end
      end
   end

endmodule

@@ hdl/pip_pack.sv @@
// ----------------------------------------------------------------------------
// Index packer
// Turns one registered request into a burst of output bytes and keeps the
// open index group between pixels.
// ----------------------------------------------------------------------------
module pip_pack import pip_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [1:0]                 req_kind,
   input  logic [15:0]                frame_width,
   input  logic [15:0]                frame_height,
   input  logic                       end_of_image,
   input  logic                       output_format,
   input  logic [CountW-1:0]          match_index,
   input  logic [PaletteMax-1:0][7:0] pal_bytes,
   output burst_type                  burst
);

   logic [PendW-1:0]  pend_ff;
   logic [PendW-1:0]  pend_in;
   logic [GroupW-1:0] gp_ff;
   logic [GroupW-1:0] gp_in;

   logic [3:0]        idx4;
   logic [2:0]        idx3;
   logic [PendW-1:0]  ins;
   logic [GroupW-1:0] gp_next;
   logic [7:0][2:0]   c;
   logic [23:0]       split;

   always_comb begin
      idx4 = (match_index > CountW'(15)) ? 4'd15 : match_index[3:0];
      idx3 = (match_index > CountW'(7)) ? 3'd7 : match_index[2:0];
      gp_next = gp_ff + GroupW'(1);
      ins = pend_ff;
      for (int p = 0; p < 7; p++) begin
         if (gp_ff == GroupW'(p)) begin
            ins[3*p +: 3] = idx3;
         end
      end
      for (int p = 0; p < 8; p++) begin
         c[p] = 3'd0;
      end
      if (gp_ff == GroupW'(7)) begin
         for (int p = 0; p < 7; p++) begin
            c[p] = pend_ff[3*p +: 3];
         end
         c[7] = idx3;
      end else begin
         // end of image: fill the missing indices with zero
         for (int p = 0; p < 7; p++) begin
            if (GroupW'(p) < gp_next || gp_next == GroupW'(0)) begin
               c[p] = ins[3*p +: 3];
            end
         end
      end
      split = pack_split(c);
   end

   always_comb begin
      pend_in = pend_ff;
      gp_in = gp_ff;
      burst = '0;
      case (req_kind)
         REQ_FRAME: begin
            burst.data[0] = frame_width[7:0];
            burst.data[1] = frame_width[15:8];
            burst.data[2] = frame_height[7:0];
            burst.data[3] = frame_height[15:8];
            for (int i = 0; i < PaletteMax; i++) begin
               burst.data[HeaderBytes + i] = pal_bytes[i];
            end
            burst.count = (output_format == FMT_NIBBLE) ? BurstCountFmt0 : BurstCountFmt1;
            pend_in = '0;
            gp_in = '0;
         end
         REQ_PIXEL: begin
            if (output_format == FMT_NIBBLE) begin
               if (gp_ff != '0) begin
                  burst.data[0] = {pend_ff[3:0], idx4};
                  burst.count = BurstCntW'(1);
                  pend_in = '0;
                  gp_in = '0;
               end else if (end_of_image) begin
                  burst.data[0] = {idx4, 4'h0};
                  burst.count = BurstCntW'(1);
                  pend_in = '0;
                  gp_in = '0;
               end else begin
                  pend_in = {{(PendW-4){1'b0}}, idx4};
                  gp_in = GroupW'(1);
               end
            end else begin
               if (gp_ff == GroupW'(7) || end_of_image) begin
                  burst.data[0] = split[7:0];
                  burst.data[1] = split[15:8];
                  burst.data[2] = split[23:16];
                  burst.count = BurstCntW'(3);
                  pend_in = '0;
                  gp_in = '0;
               end else begin
                  pend_in = ins;
                  gp_in = gp_next;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         gp_ff <= '0;
      end else if (advance) begin
         pend_ff <= pend_in;
         gp_ff <= gp_in;
      end
   end

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      advance && req_kind == REQ_FRAME |=> gp_ff == '0 && pend_ff == '0)
      else $error("frame start left an open group");

   a_split_full: assert property (@(posedge clock) disable iff (reset)
      advance && req_kind == REQ_PIXEL && output_format == FMT_SPLIT && gp_ff == GroupW'(7)
      |-> burst.count == BurstCntW'(3))
      else $error("full split group did not emit three bytes");

   a_nibble_pair: assert property (@(posedge clock) disable iff (reset)
      advance && req_kind == REQ_PIXEL && output_format == FMT_NIBBLE && gp_ff == '0
      && !end_of_image |=> gp_ff == GroupW'(1))
      else $error("nibble group did not open");

endmodule

@@ hdl/pip_serial.sv @@
// ----------------------------------------------------------------------------
// Output serializer
// Holds one burst of bytes and hands them to the response channel one per
// cycle while rsp_tready is high, marking the final byte.
// ----------------------------------------------------------------------------
module pip_serial import pip_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  burst_type burst,
   output logic      free,
   output logic      rsp_tvalid,
   input  logic      rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic      rsp_tlast
);

   logic [BurstBytes-1:0][7:0] data_ff;
   logic [BurstBytes-1:0][7:0] data_in;
   logic [BurstCntW-1:0]       cnt_ff;
   logic [BurstCntW-1:0]       cnt_in;
   logic                       take;

   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_tdata  = data_ff[0];
   assign rsp_tlast  = cnt_ff == BurstCntW'(1);
   assign take       = rsp_tvalid && rsp_tready;
   assign free       = !rsp_tvalid || (rsp_tlast && rsp_tready);

   always_comb begin
      data_in = data_ff;
      cnt_in = cnt_ff;
      if (load) begin
         data_in = burst.data;
         cnt_in = burst.count;
      end else if (take) begin
         data_in = data_ff >> 8;
         cnt_in = cnt_ff - BurstCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("burst loaded over unsent bytes");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      take && !rsp_tlast |=> rsp_tvalid)
      else $error("burst ended without a last byte");

endmodule

@@ hdl/palette_index_packer.sv @@
// ----------------------------------------------------------------------------
// Palette index packer
// Maps RGB pixels to palette indices and packs them into a byte stream.
// ----------------------------------------------------------------------------
// Requests enter on req_* (kind in tuser, end of image in tlast) and land in
// an input register. From there one pass of logic looks the color up in the
// palette and forms a burst of 0, 1, 3, 12 or 20 bytes into the output
// serializer, which drives rsp_* one byte per cycle while rsp_tready is high
// and sets tlast on the final byte of each request.
// A request's bytes pass the input register, then the serializer register.
// Throughput: one request per cycle while each burst is at most one byte
// long and rsp_tready is high; a longer burst, as from a split-format group
// or a frame start, holds back the next request that has bytes to send.
// The next request is taken while the last byte of a burst is being sent.
// Reset clears the open group, the format and count registers and both
// stages; palette slots keep no reset value and must be written before use.
// When rsp_tready is low the serializer holds its byte and the input
// register fills, then req_tready drops. Palette writes and pixels that only
// extend a group give no bytes and pass without waiting on the output.
// ----------------------------------------------------------------------------
module palette_index_packer import pip_pkg::*; #(
   parameter int PALETTE_ENTRIES = PaletteEntriesDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // entry_index[3:0], pixel_color[27:4], frame_width[43:28],
   // frame_height[59:44], zero fill[63:60]
   input  logic [63:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_byte[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [4:0]  csr_wdata
);

   localparam int SlotW = $clog2(PALETTE_ENTRIES);

   logic              fmt_ff;
   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] eff_count;

   logic              s1_valid_ff;
   logic [1:0]        kind_ff;
   logic [3:0]        slot_ff;
   logic [23:0]       color_ff;
   logic [15:0]       width_ff;
   logic [15:0]       height_ff;
   logic              eoi_ff;

   logic              s1_adv;
   logic              ser_free;
   logic              pal_we;
   logic [CountW-1:0] match_index;
   logic [PaletteMax-1:0][7:0] pal_bytes;
   burst_type         burst;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_NIBBLE;
         count_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FORMAT: fmt_ff <= csr_wdata[0];
            CSR_COUNT:  count_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      eff_count = count_ff;
      if (eff_count > CountW'(PaletteMax)) begin
         eff_count = CountW'(PaletteMax);
      end
      if (eff_count > CountW'(PALETTE_ENTRIES)) begin
         eff_count = CountW'(PALETTE_ENTRIES);
      end
   end

   // advance when the burst is empty or the serializer can take it
   assign s1_adv     = s1_valid_ff && (burst.count == '0 || ser_free);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign pal_we     = s1_adv && kind_ff == REQ_PALETTE
                       && {1'b0, slot_ff} < CountW'(PALETTE_ENTRIES);

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff <= req_tuser;
         slot_ff <= req_tdata[3:0];
         color_ff <= req_tdata[27:4];
         width_ff <= req_tdata[43:28];
         height_ff <= req_tdata[59:44];
         eoi_ff <= req_tlast;
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   pip_palette #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_palette (
      .clock       (clock),
      .wr_en       (pal_we),
      .wr_slot     (slot_ff[SlotW-1:0]),
      .color       (color_ff),
      .eff_count   (eff_count),
      .match_index (match_index),
      .pal_bytes   (pal_bytes)
   );

   pip_pack u_pack (
      .clock         (clock),
      .reset         (reset),
      .advance       (s1_adv),
      .req_kind      (kind_ff),
      .frame_width   (width_ff),
      .frame_height  (height_ff),
      .end_of_image  (eoi_ff),
      .output_format (fmt_ff),
      .match_index   (match_index),
      .pal_bytes     (pal_bytes),
      .burst         (burst)
   );

   pip_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_adv && burst.count != '0),
      .burst      (burst),
      .free       (ser_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_frame_emits: assert property (@(posedge clock) disable iff (reset)
      s1_adv && kind_ff == REQ_FRAME |=> rsp_tvalid)
      else $error("frame start produced no header");

   a_quiet_kinds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (kind_ff == REQ_PALETTE || kind_ff == REQ_UNUSED) |-> s1_adv)
      else $error("request without output stalled");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("empty input register refused a request");

endmodule
